@@ sv/kstd_pkg.sv @@
// kstd_pkg: types, constants and helper functions for the keystroke trigger detector.
// No dependencies; kstd_ctrl, kstd_dp and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package kstd_pkg;

   // Window geometry and trigger body limits
   localparam int PENDING_DEPTH = 68;
   localparam int MIN_BODY      = 2;
   localparam int MAX_BODY      = 64;

   localparam int IDX_W   = $clog2(PENDING_DEPTH);
   localparam int CNT_W   = $clog2(PENDING_DEPTH + 1);
   localparam int SUM_W   = IDX_W + 1;
   localparam int CHAR_W  = 7;
   localparam int KEY_W   = 21;
   localparam int ACT_W   = 2;
   localparam int ERASE_W = 7;

   localparam logic [CHAR_W-1:0] CH_AMP   = 7'h26;
   localparam logic [CHAR_W-1:0] CH_UNDER = 7'h5f;
   localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2d;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CH_NL    = 7'h0a;
   localparam logic [CHAR_W-1:0] CH_TAB   = 7'h09;

   typedef enum logic [ACT_W-1:0] {
      ACT_KEY       = 2'd0,
      ACT_META      = 2'd1,
      ACT_RESET     = 2'd2,
      ACT_FOCUS_OUT = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      EV_NONE,
      EV_META,
      EV_CLEAR,
      EV_FOCUS_OUT,
      EV_PUSH,
      EV_DELIM
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take;          // apply the accepted transaction
      logic rd;            // read window at pos (pos+1 with pos_inc)
      logic pos_inc;
      logic scan_step;     // fold read data into the prefix scan
      logic pos_load_run;  // point pos at the first body character
      logic out_load;      // load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      event_type ev;
      logic      quick_ok;  // length, metadata flag and field flags allow a trigger
      logic      pos_last;
      logic      body_ok;
      logic      out_free;
   } status_type;

   function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
      is_alnum = (c >= 7'h30 && c <= 7'h39) || (c >= 7'h61 && c <= 7'h7a) ||
                 (c >= 7'h41 && c <= 7'h5a);
   endfunction

   function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
      to_lower = (c >= 7'h41 && c <= 7'h5a) ? (c + 7'd32) : c;
   endfunction

   function automatic event_type classify(input logic [ACT_W-1:0] action,
                                          input logic [KEY_W-1:0] key,
                                          input logic             release_key,
                                          input logic             modifier);
      logic [CHAR_W-1:0] c;
      logic              ascii;
      c     = key[CHAR_W-1:0];
      ascii = (key[KEY_W-1:CHAR_W] == '0);
      unique case (action_type'(action))
         ACT_META:      classify = EV_META;
         ACT_RESET:     classify = EV_CLEAR;
         ACT_FOCUS_OUT: classify = EV_FOCUS_OUT;
         ACT_KEY: begin
            if (release_key)
               classify = EV_NONE;
            else if (modifier)
               classify = EV_CLEAR;
            else if (ascii && (is_alnum(c) || c == CH_AMP || c == CH_UNDER || c == CH_DASH))
               classify = EV_PUSH;
            else if (ascii && (c == CH_SPACE || c == CH_NL || c == CH_TAB))
               classify = EV_DELIM;
            else
               classify = EV_CLEAR;
         end
         default:       classify = EV_NONE;
      endcase
   endfunction

endpackage

@@ sv/kstd_ram.sv @@
// kstd_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module kstd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/kstd_ctrl.sv @@
// kstd_ctrl: sequencer for the trigger detector (accept, scan, decide, emit).
// Depends on kstd_pkg for state, command and status types.
`timescale 1ns / 1ps

module kstd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  kstd_pkg::status_type status,
   output kstd_pkg::cmd_type    cmd,
   output logic                busy
);

   kstd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= kstd_pkg::ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         kstd_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.ev == kstd_pkg::EV_DELIM && status.quick_ok)
                  state_in = kstd_pkg::ST_SCAN_RD;
            end
         end
         kstd_pkg::ST_SCAN_RD: begin
            cmd.rd   = 1'b1;
            state_in = kstd_pkg::ST_SCAN;
         end
         kstd_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.pos_last) begin
               state_in = kstd_pkg::ST_DECIDE;
            end else begin
               cmd.pos_inc = 1'b1;
               cmd.rd      = 1'b1;
            end
         end
         kstd_pkg::ST_DECIDE: begin
            if (status.body_ok) begin
               cmd.pos_load_run = 1'b1;
               state_in         = kstd_pkg::ST_EMIT_RD;
            end else begin
               state_in = kstd_pkg::ST_IDLE;
            end
         end
         kstd_pkg::ST_EMIT_RD: begin
            cmd.rd   = 1'b1;
            state_in = kstd_pkg::ST_EMIT;
         end
         kstd_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.pos_last) begin
                  state_in = kstd_pkg::ST_IDLE;
               end else begin
                  cmd.pos_inc = 1'b1;
                  cmd.rd      = 1'b1;
               end
            end
         end
         default: state_in = kstd_pkg::ST_IDLE;
      endcase
   end

   assign busy = (state_ff != kstd_pkg::ST_IDLE);

endmodule

@@ sv/kstd_dp.sv @@
// kstd_dp: window ring buffer, prefix scan, candidate registers and result register.
// Depends on kstd_pkg and kstd_ram.
`timescale 1ns / 1ps

module kstd_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  kstd_pkg::cmd_type                   cmd,
   output kstd_pkg::status_type                status,
   input  logic [kstd_pkg::ACT_W-1:0]          req_action,
   input  logic [kstd_pkg::KEY_W-1:0]          req_key_char,
   input  logic                                req_key_release,
   input  logic                                req_modifier_held,
   input  logic                                req_password_field,
   input  logic                                req_sensitive_field,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kstd_pkg::CHAR_W-1:0]         rsp_body_char,
   output logic [kstd_pkg::ERASE_W-1:0]        rsp_erase_count,
   output logic [kstd_pkg::CHAR_W-1:0]         rsp_delimiter_char,
   output logic                                rsp_last
);

   localparam logic [kstd_pkg::SUM_W-1:0] DepthSum = kstd_pkg::SUM_W'(kstd_pkg::PENDING_DEPTH);
   localparam logic [kstd_pkg::CNT_W-1:0] DepthCnt = kstd_pkg::CNT_W'(kstd_pkg::PENDING_DEPTH);

   // window ring: head is the oldest entry
   logic [kstd_pkg::IDX_W-1:0]  head_ff, head_in;
   logic [kstd_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                        meta_ff, meta_in;
   // candidate under scan
   logic [kstd_pkg::CNT_W-1:0]  len_ff, len_in;
   logic [kstd_pkg::CHAR_W-1:0] delim_ff, delim_in;
   logic [kstd_pkg::CNT_W-1:0]  pos_ff, pos_in;
   logic [kstd_pkg::CNT_W-1:0]  run_ff, run_in;
   logic                        in_run_ff, in_run_in;
   logic                        amp_after_ff, amp_after_in;
   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kstd_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic [kstd_pkg::ERASE_W-1:0] rsp_erase_ff, rsp_erase_in;
   logic [kstd_pkg::CHAR_W-1:0]  rsp_delim_ff, rsp_delim_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                        wr_en;
   logic [kstd_pkg::IDX_W-1:0]  wr_addr;
   logic [kstd_pkg::IDX_W-1:0]  rd_addr;
   logic [kstd_pkg::CHAR_W-1:0] rd_data;
   logic [kstd_pkg::CNT_W-1:0]  rd_off;
   logic [kstd_pkg::SUM_W-1:0]  rd_sum, wr_sum, head_sum;
   logic [kstd_pkg::CNT_W-1:0]  blen;
   logic                        is_amp;
   kstd_pkg::event_type         ev;

   function automatic logic [kstd_pkg::IDX_W-1:0] wrap(input logic [kstd_pkg::SUM_W-1:0] x);
      logic [kstd_pkg::SUM_W-1:0] y;
      y    = (x >= DepthSum) ? (x - DepthSum) : x;
      wrap = y[kstd_pkg::IDX_W-1:0];
   endfunction

   kstd_ram #(
      .WIDTH (kstd_pkg::CHAR_W),
      .DEPTH (kstd_pkg::PENDING_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_key_char[kstd_pkg::CHAR_W-1:0]),
      .rd_en   (cmd.rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ev = kstd_pkg::classify(req_action, req_key_char, req_key_release, req_modifier_held);

   // read address: head + pos (or pos+1 when advancing)
   assign rd_off  = cmd.pos_inc ? (pos_ff + 1'b1) : pos_ff;
   assign rd_sum  = kstd_pkg::SUM_W'(head_ff) + kstd_pkg::SUM_W'(rd_off);
   assign rd_addr = wrap(rd_sum);

   assign wr_sum   = kstd_pkg::SUM_W'(head_ff) + kstd_pkg::SUM_W'(count_ff);
   assign head_sum = kstd_pkg::SUM_W'(head_ff) + 1'b1;
   assign wr_en    = cmd.take && (ev == kstd_pkg::EV_PUSH);
   assign wr_addr  = (count_ff < DepthCnt) ? wrap(wr_sum) : head_ff;

   assign is_amp = (rd_data == kstd_pkg::CH_AMP);
   assign blen   = len_ff - run_ff;

   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      meta_in      = meta_ff;
      len_in       = len_ff;
      delim_in     = delim_ff;
      pos_in       = pos_ff;
      run_in       = run_ff;
      in_run_in    = in_run_ff;
      amp_after_in = amp_after_ff;

      if (cmd.take) begin
         pos_in       = '0;
         run_in       = '0;
         in_run_in    = 1'b1;
         amp_after_in = 1'b0;
         case (ev)
            kstd_pkg::EV_META:      meta_in = 1'b1;
            kstd_pkg::EV_CLEAR:     count_in = '0;
            kstd_pkg::EV_FOCUS_OUT: begin
               count_in = '0;
               meta_in  = 1'b0;
            end
            kstd_pkg::EV_PUSH: begin
               if (count_ff < DepthCnt)
                  count_in = count_ff + 1'b1;
               else
                  head_in = wrap(head_sum);
            end
            kstd_pkg::EV_DELIM: begin
               len_in   = count_ff;
               delim_in = req_key_char[kstd_pkg::CHAR_W-1:0];
               count_in = '0;
            end
            default: ;
         endcase
      end

      if (cmd.scan_step) begin
         if (in_run_ff && is_amp) begin
            run_in = run_ff + 1'b1;
         end else begin
            in_run_in = 1'b0;
            if (is_amp)
               amp_after_in = 1'b1;
         end
      end

      if (cmd.pos_inc)
         pos_in = pos_ff + 1'b1;
      else if (cmd.pos_load_run)
         pos_in = run_ff;
   end

   // erase count and delimiter are captured with each result, so a new
   // transaction can overwrite the candidate registers while a result waits
   always_comb begin
      rsp_char_in  = rsp_char_ff;
      rsp_erase_in = rsp_erase_ff;
      rsp_delim_in = rsp_delim_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_char_in  = kstd_pkg::to_lower(rd_data);
         rsp_erase_in = kstd_pkg::ERASE_W'(len_ff);
         rsp_delim_in = delim_ff;
         rsp_last_in  = status.pos_last;
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         meta_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         meta_ff      <= meta_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      delim_ff     <= delim_in;
      pos_ff       <= pos_in;
      run_ff       <= run_in;
      in_run_ff    <= in_run_in;
      amp_after_ff <= amp_after_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_erase_ff <= rsp_erase_in;
      rsp_delim_ff <= rsp_delim_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.ev       = ev;
   assign status.quick_ok = (count_ff >= kstd_pkg::CNT_W'(2)) && meta_ff &&
                            !req_password_field && !req_sensitive_field;
   assign status.pos_last = ((kstd_pkg::SUM_W'(pos_ff) + 1'b1) == kstd_pkg::SUM_W'(len_ff));
   assign status.body_ok  = (run_ff >= kstd_pkg::CNT_W'(2)) && !run_ff[0] && !amp_after_ff &&
                            (blen >= kstd_pkg::CNT_W'(kstd_pkg::MIN_BODY)) &&
                            (blen <= kstd_pkg::CNT_W'(kstd_pkg::MAX_BODY));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_body_char      = rsp_char_ff;
   assign rsp_erase_count    = rsp_erase_ff;
   assign rsp_delimiter_char = rsp_delim_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

@@ sv/keystroke_trigger_detector.sv @@
// keystroke_trigger_detector: top level, detects "&&body" triggers in a key event stream.
// Depends on kstd_pkg, kstd_ctrl, kstd_dp (which holds kstd_ram).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   req_    | in        | req_valid/req_stall| action, key_char, key_release,
//           |           |                    | modifier_held, password_field, sensitive
//   rsp_    | out       | rsp_valid/rsp_stall| body_char, erase_count, delimiter_char, last
//
// Flow: a transaction is absorbed in the cycle it is accepted, except a delimiter
// that passes the quick check; that delimiter holds req_stall high while the
// window RAM is walked once (one read per cycle through its registered port).
// When the body qualifies, the body characters are then read again and loaded
// into the result register one by one, holding while rsp_stall is high.
// Reset: synchronous, active high; clears window head and count, metadata flag, sequencer
// and rsp_valid. The window RAM is not cleared: only entries below the count are read.
// Stalls: the result register holds while rsp_stall is high; the next req
// transaction is taken once emission of the previous trigger is done, even while
// its last result still waits in the result register.
`timescale 1ns / 1ps

module keystroke_trigger_detector (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [kstd_pkg::ACT_W-1:0]  req_action,
   input  logic [kstd_pkg::KEY_W-1:0]  req_key_char,
   input  logic                        req_key_release,
   input  logic                        req_modifier_held,
   input  logic                        req_password_field,
   input  logic                        req_sensitive_field,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [kstd_pkg::CHAR_W-1:0] rsp_body_char,
   output logic [kstd_pkg::ERASE_W-1:0] rsp_erase_count,
   output logic [kstd_pkg::CHAR_W-1:0] rsp_delimiter_char,
   output logic                        rsp_last
);

   kstd_pkg::cmd_type    cmd;
   kstd_pkg::status_type status;
   logic                 busy;

   // Sequencer: idle -> (delimiter) scan the window -> decide -> emit body
   kstd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy)
   );

   // Window RAM, prefix scan state and result register
   kstd_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_key_char        (req_key_char),
      .req_key_release     (req_key_release),
      .req_modifier_held   (req_modifier_held),
      .req_password_field  (req_password_field),
      .req_sensitive_field (req_sensitive_field),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_body_char       (rsp_body_char),
      .rsp_erase_count     (rsp_erase_count),
      .rsp_delimiter_char  (rsp_delimiter_char),
      .rsp_last            (rsp_last)
   );

   // Transactions are taken only while the sequencer is idle
   assign req_stall = busy;

   // A new result only appears while a delimiter transaction is being worked on
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared outside of trigger emission");

   // Body characters never include the prefix character
   a_body_no_amp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_body_char != kstd_pkg::CH_AMP))
      else $error("ampersand in emitted trigger body");

   // Erase count covers at least the "&&" prefix plus the minimum body
   a_erase_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_erase_count >= kstd_pkg::ERASE_W'(kstd_pkg::MIN_BODY + 2)))
      else $error("erase count shorter than smallest trigger");

   // Delimiter is one of the three candidate terminators
   a_delim_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_delimiter_char == kstd_pkg::CH_SPACE ||
                     rsp_delimiter_char == kstd_pkg::CH_NL ||
                     rsp_delimiter_char == kstd_pkg::CH_TAB))
      else $error("unexpected delimiter on result");

endmodule
